### design/i2cbm_pkg.sv
package i2cbm_pkg;

    // Command codes carried in func; code seven has no meaning
    typedef enum logic [2:0] {
        CMD_IDLE     = 3'd0,
        CMD_START    = 3'd1,
        CMD_STOP     = 3'd2,
        CMD_WRITE    = 3'd3,
        CMD_READ     = 3'd4,
        CMD_SEND_ACK = 3'd5,
        CMD_RECV_ACK = 3'd6
    } cmd_t;

    // Func code with no command behind it, ignored like none
    localparam logic [2:0] FUNC_UNUSED = 3'd7;

    localparam logic [2:0] BIT_LAST_BYTE = 3'd7;
    localparam logic [2:0] BIT_LAST_ACK  = 3'd0;

    // Sequencer state carried from tick to tick
    typedef struct packed {
        cmd_t        cmd;
        logic [1:0]  phase;
        logic [2:0]  bit_idx;
        logic [7:0]  shift;
        logic        scl;
        logic        sda;
        logic        ack_bit;
        logic [7:0]  rx_byte;
    } seq_state_t;

    // One tick's input fields
    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  tx_data;
        logic        ack_level;
        logic        sda_sample;
    } tick_in_t;

endpackage

### design/i2cbm_step.sv
module i2cbm_step
(
    input  i2cbm_pkg::seq_state_t cur,
    input  i2cbm_pkg::tick_in_t   tick,
    output i2cbm_pkg::seq_state_t nxt,
    output logic                  done
);

    logic       take_cmd;
    logic       is_byte;
    logic [2:0] last_bit;

    // Accept a command only while idle; code seven is ignored like none
    assign take_cmd = (cur.cmd == i2cbm_pkg::CMD_IDLE)
                   && (tick.func != 3'(i2cbm_pkg::CMD_IDLE))
                   && (tick.func != i2cbm_pkg::FUNC_UNUSED);

    always_comb
    begin
        nxt      = cur;
        done     = 1'b0;
        is_byte  = 1'b0;
        last_bit = i2cbm_pkg::BIT_LAST_ACK;

        // Load the new command; its first step runs on this same tick
        if (take_cmd)
        begin
            nxt.cmd     = i2cbm_pkg::cmd_t'(tick.func);
            nxt.phase   = 2'd0;
            nxt.bit_idx = 3'd0;
            if (tick.func == 3'(i2cbm_pkg::CMD_WRITE))
                nxt.shift = tick.tx_data;
            else if (tick.func == 3'(i2cbm_pkg::CMD_SEND_ACK))
                nxt.shift = {tick.ack_level, 7'd0};
            else
                nxt.shift = 8'd0;
        end

        unique case (nxt.cmd)
            i2cbm_pkg::CMD_IDLE:
            begin
            end
            i2cbm_pkg::CMD_START:
            begin
                case (nxt.phase)
                    2'd0: nxt.sda = 1'b1;
                    2'd1: nxt.scl = 1'b1;
                    2'd2: nxt.sda = 1'b0;
                    default: nxt.scl = 1'b0;
                endcase
                if (nxt.phase == 2'd3)
                begin
                    nxt.cmd     = i2cbm_pkg::CMD_IDLE;
                    nxt.phase   = 2'd0;
                    nxt.bit_idx = 3'd0;
                    done        = 1'b1;
                end
                else
                    nxt.phase = nxt.phase + 2'd1;
            end
            i2cbm_pkg::CMD_STOP:
            begin
                case (nxt.phase)
                    2'd0: nxt.sda = 1'b0;
                    2'd1: nxt.scl = 1'b1;
                    default: nxt.sda = 1'b1;
                endcase
                if (nxt.phase[1])
                begin
                    nxt.cmd     = i2cbm_pkg::CMD_IDLE;
                    nxt.phase   = 2'd0;
                    nxt.bit_idx = 3'd0;
                    done        = 1'b1;
                end
                else
                    nxt.phase = nxt.phase + 2'd1;
            end
            i2cbm_pkg::CMD_WRITE, i2cbm_pkg::CMD_READ,
            i2cbm_pkg::CMD_SEND_ACK, i2cbm_pkg::CMD_RECV_ACK:
            begin
                // Bit cell: set SDA, release SCL, then sample and pull SCL low
                is_byte  = (nxt.cmd == i2cbm_pkg::CMD_WRITE)
                        || (nxt.cmd == i2cbm_pkg::CMD_READ);
                last_bit = is_byte ? i2cbm_pkg::BIT_LAST_BYTE : i2cbm_pkg::BIT_LAST_ACK;
                if (nxt.phase == 2'd0)
                begin
                    if ((nxt.cmd == i2cbm_pkg::CMD_WRITE)
                        || (nxt.cmd == i2cbm_pkg::CMD_SEND_ACK))
                        nxt.sda = nxt.shift[7];
                    else
                        nxt.sda = 1'b1;
                    nxt.phase = 2'd1;
                end
                else if (nxt.phase == 2'd1)
                begin
                    nxt.scl   = 1'b1;
                    nxt.phase = 2'd2;
                end
                else
                begin
                    nxt.shift = {nxt.shift[6:0],
                                 (nxt.cmd == i2cbm_pkg::CMD_READ) & tick.sda_sample};
                    if (nxt.cmd == i2cbm_pkg::CMD_RECV_ACK)
                        nxt.ack_bit = tick.sda_sample;
                    nxt.scl = 1'b0;
                    if (nxt.bit_idx >= last_bit)
                    begin
                        if (nxt.cmd == i2cbm_pkg::CMD_READ)
                            nxt.rx_byte = nxt.shift;
                        nxt.cmd     = i2cbm_pkg::CMD_IDLE;
                        nxt.phase   = 2'd0;
                        nxt.bit_idx = 3'd0;
                        done        = 1'b1;
                    end
                    else
                    begin
                        nxt.bit_idx = nxt.bit_idx + 3'd1;
                        nxt.phase   = 2'd0;
                    end
                end
            end
            default:
            begin
                nxt.cmd = i2cbm_pkg::CMD_IDLE;
            end
        endcase
    end

endmodule

### design/i2c_bit_level_master.sv
// Each accepted input transaction has its result on m_tdata in the next cycle.
// One transaction per cycle while the result side drains; each tick is a single pass through
// the step logic between the sequencer state register and the output register.
// Reset (rst_n low, asynchronous): master idle, SCL and SDA released,
// received byte zero, ack bit one, no result pending.
module i2c_bit_level_master
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // func[2:0], tx_data[10:3], ack_level[11], sda_sample[12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // scl_level[0], sda_level[1], busy_res[2], done_res[3],
                                  // rx_data[11:4], ack_seen[12]
);

    i2cbm_pkg::seq_state_t state_reg;
    i2cbm_pkg::seq_state_t state_next;
    i2cbm_pkg::tick_in_t   tick;
    logic                  step_done;
    logic                  in_fire;
    logic                  out_valid_reg;
    logic [15:0]           out_data_reg;

    // Unpack the input transaction
    assign tick.func       = s_tdata[2:0];
    assign tick.tx_data    = s_tdata[10:3];
    assign tick.ack_level  = s_tdata[11];
    assign tick.sda_sample = s_tdata[12];

    // Take a tick whenever the output register is empty or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    i2cbm_step u_step
    (
        .cur  (state_reg),
        .tick (tick),
        .nxt  (state_next),
        .done (step_done)
    );

    // Advance the sequencer on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.cmd     <= i2cbm_pkg::CMD_IDLE;
            state_reg.phase   <= 2'd0;
            state_reg.bit_idx <= 3'd0;
            state_reg.shift   <= 8'd0;
            state_reg.scl     <= 1'b1;
            state_reg.sda     <= 1'b1;
            state_reg.ack_bit <= 1'b1;
            state_reg.rx_byte <= 8'd0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_data_reg <= {3'd0, state_next.ack_bit, state_next.rx_byte, step_done,
                             (state_next.cmd != i2cbm_pkg::CMD_IDLE),
                             state_next.sda, state_next.scl};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### design/i2cbm_checker.sv
module i2cbm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // Every accepted tick yields a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted tick produced no result");

    // A finishing tick reports the master as no longer busy
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> !m_tdata[2])
    else $error("done reported while still busy");

    // An empty output side never stalls the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
    else $error("input stalled with no result pending");

    // A stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

    // Padding bits stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:13] == 3'd0))
    else $error("nonzero padding in result");

endmodule

bind i2c_bit_level_master i2cbm_checker u_i2cbm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### bench/tb_i2c_bit_level_master.sv
`timescale 1ns / 100ps

module tb_i2c_bit_level_master;

    localparam logic [7:0] ACK_MSB_MASK = 8'h80;
    localparam int         CYCLE_LIMIT  = 300000;
    localparam int         REPORT_MAX   = 10;

    // Pin levels and status reported for one tick
    typedef struct packed {
        logic        scl;
        logic        sda;
        logic        busy;
        logic        done;
        logic [7:0]  rx_data;
        logic        ack_seen;
    } pin_result_t;

    // Tracks the bit engine's sequencer and the pin results still owed
    class i2c_pin_scoreboard;
        i2cbm_pkg::cmd_t cmd;
        logic [1:0]      phase;
        logic [2:0]      bit_idx;
        logic [7:0]      shift;
        logic            scl;
        logic            sda;
        logic            ack_bit;
        logic [7:0]      rx_byte;
        pin_result_t     owed[$];
        int              errors;

        function new();
            cmd     = i2cbm_pkg::CMD_IDLE;
            phase   = 2'd0;
            bit_idx = 3'd0;
            shift   = 8'h00;
            scl     = 1'b1;
            sda     = 1'b1;
            ack_bit = 1'b1;
            rx_byte = 8'h00;
            errors  = 0;
        endfunction

        function bit idle();
            return cmd == i2cbm_pkg::CMD_IDLE;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Advance the sequencer by one tick and queue the pin levels it leads to
        function void note_tick(i2cbm_pkg::tick_in_t t);
            pin_result_t r;
            logic        finished;
            logic [2:0]  last_bit;
            finished = 1'b0;

            // Latch a new command only while idle
            if (cmd == i2cbm_pkg::CMD_IDLE && t.func >= i2cbm_pkg::CMD_START
                && t.func <= i2cbm_pkg::CMD_RECV_ACK) begin
                cmd     = i2cbm_pkg::cmd_t'(t.func);
                phase   = 2'd0;
                bit_idx = 3'd0;
                case (cmd)
                    i2cbm_pkg::CMD_WRITE:    shift = t.tx_data;
                    i2cbm_pkg::CMD_SEND_ACK: shift = t.ack_level ? ACK_MSB_MASK : 8'h00;
                    default:                 shift = 8'h00;
                endcase
            end

            case (cmd)
                i2cbm_pkg::CMD_IDLE:
                begin
                end
                i2cbm_pkg::CMD_START:
                begin
                    case (phase)
                        2'd0: sda = 1'b1;
                        2'd1: scl = 1'b1;
                        2'd2: sda = 1'b0;
                        default:
                        begin
                            scl      = 1'b0;
                            finished = 1'b1;
                        end
                    endcase
                    phase = phase + 2'd1;
                end
                i2cbm_pkg::CMD_STOP:
                begin
                    case (phase)
                        2'd0: sda = 1'b0;
                        2'd1: scl = 1'b1;
                        default:
                        begin
                            sda      = 1'b1;
                            finished = 1'b1;
                        end
                    endcase
                    phase = phase + 2'd1;
                end
                default:
                begin
                    // One bit cell: set data, raise SCL, sample and drop SCL
                    if (phase == 2'd0) begin
                        if (cmd == i2cbm_pkg::CMD_WRITE || cmd == i2cbm_pkg::CMD_SEND_ACK)
                            sda = shift[7];
                        else
                            sda = 1'b1;
                        phase = 2'd1;
                    end
                    else if (phase == 2'd1) begin
                        scl   = 1'b1;
                        phase = 2'd2;
                    end
                    else begin
                        if (cmd == i2cbm_pkg::CMD_READ)
                            shift = {shift[6:0], t.sda_sample};
                        else
                            shift = {shift[6:0], 1'b0};
                        if (cmd == i2cbm_pkg::CMD_RECV_ACK)
                            ack_bit = t.sda_sample;
                        scl = 1'b0;
                        last_bit = (cmd == i2cbm_pkg::CMD_WRITE
                                    || cmd == i2cbm_pkg::CMD_READ) ?
                                   i2cbm_pkg::BIT_LAST_BYTE : i2cbm_pkg::BIT_LAST_ACK;
                        if (bit_idx >= last_bit) begin
                            if (cmd == i2cbm_pkg::CMD_READ)
                                rx_byte = shift;
                            finished = 1'b1;
                        end
                        else begin
                            bit_idx = bit_idx + 3'd1;
                            phase   = 2'd0;
                        end
                    end
                end
            endcase

            if (finished) begin
                cmd     = i2cbm_pkg::CMD_IDLE;
                phase   = 2'd0;
                bit_idx = 3'd0;
            end

            r.scl      = scl;
            r.sda      = sda;
            r.busy     = (cmd != i2cbm_pkg::CMD_IDLE);
            r.done     = finished;
            r.rx_data  = rx_byte;
            r.ack_seen = ack_bit;
            owed.push_back(r);
        endfunction

        function void field_check(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("mismatch on %s: expected %0h, got %0h", name, want, got);
            end
        endfunction

        // Compare one accepted result with the oldest owed one
        function void check_pins(logic [15:0] data);
            pin_result_t want;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result %04h with nothing owed", data);
                return;
            end
            want = owed.pop_front();
            field_check("scl_level", {7'd0, want.scl},      {7'd0, data[0]});
            field_check("sda_level", {7'd0, want.sda},      {7'd0, data[1]});
            field_check("busy",      {7'd0, want.busy},     {7'd0, data[2]});
            field_check("done",      {7'd0, want.done},     {7'd0, data[3]});
            field_check("rx_data",   want.rx_data,          data[11:4]);
            field_check("ack_seen",  {7'd0, want.ack_seen}, {7'd0, data[12]});
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = 16'h0000;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [15:0] m_tdata;

    int                send_idle_pct = 0;
    int                stall_pct     = 0;
    int                cycle_count   = 0;
    i2cbm_pkg::cmd_t   plan[$];
    i2c_pin_scoreboard sb = new();

    i2c_bit_level_master u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Check each result transaction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_pins(m_tdata);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one tick, hold it until accepted, then note it
    task automatic send_tick(input i2cbm_pkg::tick_in_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, t.sda_sample, t.ack_level, t.tx_data, t.func};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_tick(t);
    endtask

    // Issue a command, then keep ticking with random noise until it completes
    task automatic run_command(input i2cbm_pkg::cmd_t cmd, input logic [7:0] tx,
                               input logic ack, input logic sda_in);
        i2cbm_pkg::tick_in_t t;
        t.func       = cmd;
        t.tx_data    = tx;
        t.ack_level  = ack;
        t.sda_sample = sda_in;
        send_tick(t);
        while (!sb.idle()) begin
            t.func = 3'($urandom_range(7));
            send_tick(t);
        end
    endtask

    // Random tick: mostly whole transfers, some noise and broken transfers
    task automatic random_tick();
        i2cbm_pkg::tick_in_t t;
        int                  pick;
        int                  nbytes;
        t.tx_data    = 8'($urandom_range(255));
        t.ack_level  = 1'($urandom_range(1));
        t.sda_sample = 1'($urandom_range(1));
        if (!sb.idle()) begin
            t.func = ($urandom_range(99) < 20) ? 3'($urandom_range(7))
                                               : 3'(i2cbm_pkg::CMD_IDLE);
        end
        else begin
            if (plan.size() == 0) begin
                plan.push_back(i2cbm_pkg::CMD_START);
                plan.push_back(i2cbm_pkg::CMD_WRITE);
                plan.push_back(i2cbm_pkg::CMD_RECV_ACK);
                nbytes = $urandom_range(1, 3);
                for (int i = 0; i < nbytes; i++) begin
                    if ($urandom_range(1)) begin
                        plan.push_back(i2cbm_pkg::CMD_READ);
                        plan.push_back(i2cbm_pkg::CMD_SEND_ACK);
                    end
                    else begin
                        plan.push_back(i2cbm_pkg::CMD_WRITE);
                        plan.push_back(i2cbm_pkg::CMD_RECV_ACK);
                    end
                end
                plan.push_back(i2cbm_pkg::CMD_STOP);
            end
            pick = $urandom_range(99);
            if (pick < 4)
                plan.delete();
            if (pick < 12 || plan.size() == 0)
                t.func = 3'($urandom_range(7));
            else
                t.func = plan.pop_front();
        end
        send_tick(t);
    endtask

    // Drop valid and hold off until every owed result has arrived
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        i2cbm_pkg::tick_in_t t;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle ticks, unused code, every command at its extremes
        t = '{func: i2cbm_pkg::CMD_IDLE, tx_data: 8'h00, ack_level: 1'b0, sda_sample: 1'b0};
        send_tick(t);
        t.func = i2cbm_pkg::FUNC_UNUSED;
        send_tick(t);
        run_command(i2cbm_pkg::CMD_START,    8'h00, 1'b0, 1'b0);
        run_command(i2cbm_pkg::CMD_WRITE,    8'hFF, 1'b1, 1'b1);
        run_command(i2cbm_pkg::CMD_WRITE,    8'h00, 1'b0, 1'b0);
        run_command(i2cbm_pkg::CMD_RECV_ACK, 8'h00, 1'b0, 1'b0);
        run_command(i2cbm_pkg::CMD_RECV_ACK, 8'hFF, 1'b1, 1'b1);
        run_command(i2cbm_pkg::CMD_READ,     8'h00, 1'b0, 1'b1);
        run_command(i2cbm_pkg::CMD_READ,     8'hFF, 1'b1, 1'b0);
        run_command(i2cbm_pkg::CMD_SEND_ACK, 8'hFF, 1'b0, 1'b1);
        run_command(i2cbm_pkg::CMD_SEND_ACK, 8'h00, 1'b1, 1'b0);
        run_command(i2cbm_pkg::CMD_STOP,     8'h00, 1'b0, 1'b1);

        // Random phases with varying idle and stall pressure
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 59; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 7; stall_pct = 7; end
            endcase
            for (int i = 0; i < 184; i++)
                random_tick();
            drain();
        end

        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
